[sv/sparse_coo_matrix_multiply_top_assert.svh]
// Assertion macros used by the sparse COO multiply engine
`ifndef SPARSE_COO_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SPARSE_COO_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define SCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/scm_pkg.sv]
// Types and constants of the sparse COO matrix multiply block
package scm_pkg;

    localparam int LEFT_CAP    = 16;
    localparam int RIGHT_CAP   = 16;
    localparam int RES_CAP     = 64;
    localparam int DIMENSION   = 256;

    localparam int LEFT_IW  = $clog2(LEFT_CAP);
    localparam int LEFT_CW  = $clog2(LEFT_CAP + 1);
    localparam int RIGHT_IW = $clog2(RIGHT_CAP);
    localparam int RIGHT_CW = $clog2(RIGHT_CAP + 1);
    localparam int RES_IW   = $clog2(RES_CAP);
    localparam int RES_CW   = $clog2(RES_CAP + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] CMD_MULTIPLY   = 2'd2;

    localparam logic [30:0] THR_RESET = 31'd1311;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
    } scm_item_t;

    typedef struct packed {
        logic      valid;
        scm_item_t item;
    } scm_push_t;

    typedef struct packed {
        logic      valid;
        scm_item_t item;
    } scm_head_t;

    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
    } scm_entry_t;

endpackage

[sv/scm_front.sv]
// Front end: accepts input beats, drops unused commands and out-of-range loads
module scm_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 queue_full,
    output scm_pkg::scm_push_t   push
);

    logic        in_range;
    logic        keep;

    assign in_range = ({9'd0, s_tdata[7:0]} < 17'(scm_pkg::DIMENSION))
                   && ({9'd0, s_tdata[15:8]} < 17'(scm_pkg::DIMENSION));

    always_comb begin
        unique case (s_tuser)
            scm_pkg::CMD_LOAD_LEFT:  keep = in_range;
            scm_pkg::CMD_LOAD_RIGHT: keep = in_range;
            scm_pkg::CMD_MULTIPLY:   keep = 1'b1;
            default:                 keep = 1'b0;
        endcase
    end

    assign s_tready        = !queue_full;
    assign push.valid      = s_tvalid && !queue_full && keep;
    assign push.item.cmd   = s_tuser;
    assign push.item.row   = s_tdata[7:0];
    assign push.item.col   = s_tdata[15:8];
    assign push.item.value = $signed(s_tdata[47:16]);

endmodule

[sv/scm_queue.sv]
// Short command queue between front end and engine
module scm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  scm_pkg::scm_push_t  push,
    input  logic                pop,
    output scm_pkg::scm_head_t  head,
    output logic                full
);

    scm_pkg::scm_item_t                 slot_reg [scm_pkg::QUEUE_DEPTH];
    logic [scm_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [scm_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [scm_pkg::QUEUE_CW-1:0]       count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign full       = (count_reg == scm_pkg::QUEUE_CW'(scm_pkg::QUEUE_DEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/scm_engine.sv]
// Engine: holds the stores, walks all pairs, accumulates and emits results
module scm_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  scm_pkg::scm_head_t  head,
    output logic                pop,
    input  logic [30:0]         drop_threshold,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PAIR     = 4'd1;
    localparam logic [3:0] ST_MUL      = 4'd2;
    localparam logic [3:0] ST_SCAN_RD  = 4'd3;
    localparam logic [3:0] ST_SCAN_CMP = 4'd4;
    localparam logic [3:0] ST_EMIT_RD  = 4'd5;
    localparam logic [3:0] ST_EMIT_LD  = 4'd6;
    localparam logic [3:0] ST_EMPTY    = 4'd7;

    logic [3:0]                    state_reg;
    logic [scm_pkg::LEFT_CW-1:0]   lcount_reg;
    logic [scm_pkg::RIGHT_CW-1:0]  rcount_reg;
    logic [scm_pkg::RES_CW-1:0]    pcount_reg;
    logic [scm_pkg::LEFT_CW-1:0]   li_reg;
    logic [scm_pkg::RIGHT_CW-1:0]  rj_reg;
    logic [scm_pkg::RES_CW-1:0]    k_reg;
    logic                          ovf_reg;

    logic [7:0]                    left_row_mem [scm_pkg::LEFT_CAP];
    logic [7:0]                    left_col_mem [scm_pkg::LEFT_CAP];
    logic signed [31:0]            left_val_mem [scm_pkg::LEFT_CAP];
    logic [7:0]                    right_row_mem [scm_pkg::RIGHT_CAP];
    logic [7:0]                    right_col_mem [scm_pkg::RIGHT_CAP];
    logic signed [31:0]            right_val_mem [scm_pkg::RIGHT_CAP];
    scm_pkg::scm_entry_t           prod_mem [scm_pkg::RES_CAP];
    scm_pkg::scm_entry_t           rd_q_reg;

    logic signed [63:0]            prod_reg;
    logic signed [31:0]            x_reg;
    logic [7:0]                    key_row_reg;
    logic [7:0]                    key_col_reg;

    logic                          m_tvalid_reg;
    logic [47:0]                   m_tdata_reg;
    logic                          m_tlast_reg;
    logic [1:0]                    m_tuser_reg;

    logic [scm_pkg::LEFT_IW-1:0]   li_idx;
    logic [scm_pkg::RIGHT_IW-1:0]  rj_idx;
    logic signed [63:0]            shifted;
    logic signed [31:0]            x_sat;
    logic signed [32:0]            x_ext;
    logic [32:0]                   x_mag;
    logic                          x_keep;
    logic signed [32:0]            sum_ext;
    logic signed [31:0]            sum_sat;
    logic                          out_free;
    logic                          beat_load;
    logic                          load_left;
    logic                          load_right;
    logic                          emit_last;
    logic                          mem_we;
    logic [scm_pkg::RES_IW-1:0]    mem_waddr;
    scm_pkg::scm_entry_t           mem_wdata;
    logic                          hit;

    assign li_idx = li_reg[scm_pkg::LEFT_IW-1:0];
    assign rj_idx = rj_reg[scm_pkg::RIGHT_IW-1:0];

    // floor shift, then saturate to 32 bits
    assign shifted = prod_reg >>> 16;
    always_comb begin
        if ((&shifted[63:31]) || !(|shifted[63:31])) begin
            x_sat = shifted[31:0];
        end else if (shifted[63]) begin
            x_sat = 32'sh8000_0000;
        end else begin
            x_sat = 32'sh7fff_ffff;
        end
    end
    assign x_ext  = {x_sat[31], x_sat};
    assign x_mag  = x_sat[31] ? 33'(-x_ext) : 33'(x_ext);
    assign x_keep = x_mag > {2'b00, drop_threshold};

    assign sum_ext = {rd_q_reg.value[31], rd_q_reg.value} + {x_reg[31], x_reg};
    always_comb begin
        if (sum_ext[32] == sum_ext[31]) begin
            sum_sat = sum_ext[31:0];
        end else if (sum_ext[32]) begin
            sum_sat = 32'sh8000_0000;
        end else begin
            sum_sat = 32'sh7fff_ffff;
        end
    end

    assign hit        = (rd_q_reg.row == key_row_reg) && (rd_q_reg.col == key_col_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign beat_load  = ((state_reg == ST_EMIT_LD) || (state_reg == ST_EMPTY)) && out_free;
    assign pop        = (state_reg == ST_IDLE) && head.valid;
    assign load_left  = pop && (head.item.cmd == scm_pkg::CMD_LOAD_LEFT)
                     && (lcount_reg < scm_pkg::LEFT_CW'(scm_pkg::LEFT_CAP));
    assign load_right = pop && (head.item.cmd == scm_pkg::CMD_LOAD_RIGHT)
                     && (rcount_reg < scm_pkg::RIGHT_CW'(scm_pkg::RIGHT_CAP));
    assign emit_last  = ((k_reg + scm_pkg::RES_CW'(1)) == pcount_reg);

    // result store write: append a new entry or update a matched one
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = k_reg[scm_pkg::RES_IW-1:0];
        mem_wdata = '{row: key_row_reg, col: key_col_reg, value: x_reg};
        if (state_reg == ST_SCAN_CMP) begin
            if (k_reg >= pcount_reg) begin
                mem_we    = (pcount_reg < scm_pkg::RES_CW'(scm_pkg::RES_CAP));
                mem_waddr = pcount_reg[scm_pkg::RES_IW-1:0];
            end else if (hit) begin
                mem_we          = 1'b1;
                mem_wdata.value = sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_left) begin
            left_row_mem[lcount_reg[scm_pkg::LEFT_IW-1:0]] <= head.item.row;
            left_col_mem[lcount_reg[scm_pkg::LEFT_IW-1:0]] <= head.item.col;
            left_val_mem[lcount_reg[scm_pkg::LEFT_IW-1:0]] <= head.item.value;
        end
        if (load_right) begin
            right_row_mem[rcount_reg[scm_pkg::RIGHT_IW-1:0]] <= head.item.row;
            right_col_mem[rcount_reg[scm_pkg::RIGHT_IW-1:0]] <= head.item.col;
            right_val_mem[rcount_reg[scm_pkg::RIGHT_IW-1:0]] <= head.item.value;
        end
        if (mem_we) begin
            prod_mem[mem_waddr] <= mem_wdata;
        end
        rd_q_reg <= prod_mem[k_reg[scm_pkg::RES_IW-1:0]];
    end

    // pair operands and product
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PAIR) begin
            prod_reg    <= left_val_mem[li_idx] * right_val_mem[rj_idx];
            key_row_reg <= left_row_mem[li_idx];
            key_col_reg <= right_col_mem[rj_idx];
        end
        if (state_reg == ST_MUL) begin
            x_reg <= x_sat;
        end
    end

    // output valid: load a new beat or drop the accepted one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (beat_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lcount_reg   <= '0;
            rcount_reg   <= '0;
            pcount_reg   <= '0;
            li_reg       <= '0;
            rj_reg       <= '0;
            k_reg        <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        unique case (head.item.cmd)
                            scm_pkg::CMD_LOAD_LEFT: begin
                                if (load_left) lcount_reg <= lcount_reg + 1'b1;
                                else           ovf_reg    <= 1'b1;
                            end
                            scm_pkg::CMD_LOAD_RIGHT: begin
                                if (load_right) rcount_reg <= rcount_reg + 1'b1;
                                else            ovf_reg    <= 1'b1;
                            end
                            default: begin
                                li_reg     <= '0;
                                rj_reg     <= '0;
                                pcount_reg <= '0;
                                state_reg  <= ST_PAIR;
                            end
                        endcase
                    end
                end
                ST_PAIR: begin
                    if (li_reg >= lcount_reg) begin
                        k_reg     <= '0;
                        state_reg <= (pcount_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
                    end else if (rj_reg >= rcount_reg) begin
                        li_reg <= li_reg + 1'b1;
                        rj_reg <= '0;
                    end else if (left_col_mem[li_idx] == right_row_mem[rj_idx]) begin
                        state_reg <= ST_MUL;
                    end else begin
                        rj_reg <= rj_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    if (x_keep) begin
                        k_reg     <= '0;
                        state_reg <= ST_SCAN_RD;
                    end else begin
                        rj_reg    <= rj_reg + 1'b1;
                        state_reg <= ST_PAIR;
                    end
                end
                ST_SCAN_RD: begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP: begin
                    if (k_reg >= pcount_reg) begin
                        if (pcount_reg < scm_pkg::RES_CW'(scm_pkg::RES_CAP)) begin
                            pcount_reg <= pcount_reg + 1'b1;
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        rj_reg    <= rj_reg + 1'b1;
                        state_reg <= ST_PAIR;
                    end else if (hit) begin
                        rj_reg    <= rj_reg + 1'b1;
                        state_reg <= ST_PAIR;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    if (out_free) begin
                        if (emit_last) begin
                            lcount_reg <= '0;
                            rcount_reg <= '0;
                            pcount_reg <= '0;
                            ovf_reg    <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        lcount_reg   <= '0;
                        rcount_reg   <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT_LD) && out_free) begin
            m_tdata_reg <= {rd_q_reg.value, rd_q_reg.col, rd_q_reg.row};
            m_tlast_reg <= emit_last;
            m_tuser_reg <= {ovf_reg, 1'b0};
        end else if ((state_reg == ST_EMPTY) && out_free) begin
            m_tdata_reg <= '0;
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= {ovf_reg, 1'b1};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`include "sparse_coo_matrix_multiply_top_assert.svh"

    `SCM_ASSERT(a_pcount_cap, pcount_reg <= scm_pkg::RES_CW'(scm_pkg::RES_CAP), "result count over capacity")
    `SCM_ASSERT(a_lcount_cap, lcount_reg <= scm_pkg::LEFT_CW'(scm_pkg::LEFT_CAP), "left count over capacity")
    `SCM_ASSERT(a_pop_idle, pop |-> (state_reg == ST_IDLE), "queue popped while busy")
    `SCM_ASSERT(a_done_clear, ((state_reg == ST_EMPTY) && out_free) |=> (lcount_reg == '0 && rcount_reg == '0 && !ovf_reg), "stores not cleared after multiply")

endmodule

[sv/sparse_coo_matrix_multiply_top.sv]
// Top level of the sparse COO matrix multiply block
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | tuser command, tdata row/col/value
//  m_      | out | m_tvalid / m_tready  | tdata row/col/value, tlast, tuser flags
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data drop threshold
//
// Loads are taken by the engine while it is idle; the queue takes a beat a cycle while not full.
// A multiply walks every left/right pair, one pair a cycle while pairs do not match, with a
// step per left entry and one to finish; a matching pair adds a multiply step, a kept product
// a serial scan of the result entries, then each entry is read and emitted (one beat if empty).
// Reset (aresetn low, synchronous) empties queue and stores; threshold returns to 1311.
// A stalled m_ side holds the engine; the queue keeps taking beats until full.
module sparse_coo_matrix_multiply_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[7:0], col[15:8], value[47:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_row[7:0], out_col[15:8], out_value[47:16]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // empty_res[0], overflow[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    scm_pkg::scm_push_t push;
    scm_pkg::scm_head_t head;
    logic               queue_full;
    logic               pop;
    logic [30:0]        thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= scm_pkg::THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    scm_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push)
    );

    scm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (queue_full)
    );

    scm_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .pop            (pop),
        .drop_threshold (thr_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser)
    );

endmodule

[tb/scm_checker.sv]
// Result checker: watches the sparse multiply channels, predicts products and compares
module scm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [30:0] cfg_data,
    output int          mismatch_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] value;
        logic        last;
        logic        empty_res;
        logic        overflow;
    } beat_t;

    logic [30:0]          threshold;
    scm_pkg::scm_entry_t  left_store[$];
    scm_pkg::scm_entry_t  right_store[$];
    scm_pkg::scm_entry_t  product_store[$];
    logic                 overflow_seen;
    beat_t                expected_beats[$];

    assign pending_results = expected_beats.size();

    function automatic logic signed [31:0] saturate(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Arithmetic shift floors, which is the rounding the block wants
    function automatic logic signed [31:0] q_multiply(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return saturate(p >>> 16);
    endfunction

    task automatic add_product(logic [7:0] r, logic [7:0] c, logic signed [31:0] x);
        foreach (product_store[k]) begin
            if (product_store[k].row == r && product_store[k].col == c) begin
                product_store[k].value = saturate(64'(product_store[k].value) + 64'(x));
                return;
            end
        end
        if (product_store.size() < scm_pkg::RES_CAP)
            product_store.push_back('{r, c, x});
        else
            overflow_seen = 1'b1;
    endtask

    task automatic compute_product();
        logic signed [31:0] x;
        logic [32:0] mag;
        product_store.delete();
        foreach (left_store[i])
            foreach (right_store[j])
                if (left_store[i].col == right_store[j].row) begin
                    x = q_multiply(left_store[i].value, right_store[j].value);
                    mag = x < 0 ? 33'(-34'(x)) : 33'(x);
                    if (mag > 33'(threshold))
                        add_product(left_store[i].row, right_store[j].col, x);
                end
        if (product_store.size() == 0)
            expected_beats.push_back('{8'd0, 8'd0, 32'd0, 1'b1, 1'b1, overflow_seen});
        else
            foreach (product_store[k])
                expected_beats.push_back('{product_store[k].row, product_store[k].col,
                    product_store[k].value, k == product_store.size() - 1, 1'b0,
                    overflow_seen});
        left_store.delete();
        right_store.delete();
        overflow_seen = 1'b0;
    endtask

    always @(posedge aclk) begin
        beat_t                want;
        beat_t                got;
        scm_pkg::scm_entry_t  e;
        if (!aresetn) begin
            threshold       <= scm_pkg::THR_RESET;
            overflow_seen   = 1'b0;
            mismatch_count  <= 0;
            left_store.delete();
            right_store.delete();
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) threshold <= cfg_data;
            if (s_tvalid && s_tready) begin
                e = '{s_tdata[7:0], s_tdata[15:8], s_tdata[47:16]};
                case (s_tuser)
                    scm_pkg::CMD_LOAD_LEFT: begin
                        if (left_store.size() < scm_pkg::LEFT_CAP) left_store.push_back(e);
                        else overflow_seen = 1'b1;
                    end
                    scm_pkg::CMD_LOAD_RIGHT: begin
                        if (right_store.size() < scm_pkg::RIGHT_CAP) right_store.push_back(e);
                        else overflow_seen = 1'b1;
                    end
                    scm_pkg::CMD_MULTIPLY: compute_product();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tlast,
                        m_tuser[0], m_tuser[1]};
                if (expected_beats.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result beat %p", got);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display("result mismatch: expected %p got %p", want, got);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/testbench.sv]
// Top of the sparse COO multiply testbench: stimulus, reset, watchdog and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;
    int          mismatch_count;
    int          pending_results;
    int          quiet_cycles;
    bit          stall_enable;

    sparse_coo_matrix_multiply_top dut (.*);

    scm_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver stalls at random while stall_enable is set; some stretches have no stall at all
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (!stall_enable) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: count cycles with no accepted beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic [7:0] r, logic [7:0] c,
                             logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {v, c, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // now and then drop valid after a beat to leave a gap
        if ($urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        // a multiply with no kept product may still be working
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [30:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
        endcase
    endfunction

    task automatic random_matrix_pair(int nl, int nr);
        logic [7:0] span;
        logic [1:0] cmd;
        span = $urandom_range(0, 3) == 0 ? 8'd255 : 8'd3;
        for (int k = 0; k < nl + nr; k++) begin
            cmd = (k < nl) ? scm_pkg::CMD_LOAD_LEFT : scm_pkg::CMD_LOAD_RIGHT;
            if ($urandom_range(0, 1)) cmd = 2'($urandom_range(0, 1));
            if ($urandom_range(0, 19) == 0) cmd = 2'd3;
            send_beat(cmd, 8'($urandom_range(0, span)), 8'($urandom_range(0, span)),
                      random_value());
        end
        send_beat(scm_pkg::CMD_MULTIPLY, 8'($urandom()), 8'($urandom()), $urandom());
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        stall_enable = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty product, extremes, accumulation, unused command
        send_beat(scm_pkg::CMD_MULTIPLY, 8'd0, 8'd0, 32'd0);
        send_beat(scm_pkg::CMD_LOAD_LEFT, 8'd255, 8'd0, 32'h7fffffff);
        send_beat(scm_pkg::CMD_LOAD_LEFT, 8'd255, 8'd0, 32'h80000000);
        send_beat(scm_pkg::CMD_LOAD_LEFT, 8'd0, 8'd255, 32'hffffffff);
        send_beat(scm_pkg::CMD_LOAD_RIGHT, 8'd0, 8'd255, 32'h7fffffff);
        send_beat(scm_pkg::CMD_LOAD_RIGHT, 8'd255, 8'd7, 32'h80000000);
        send_beat(2'd3, 8'hff, 8'hff, 32'hffffffff);
        send_beat(scm_pkg::CMD_MULTIPLY, 8'd0, 8'd0, 32'd0);
        // full left store: overflow flag
        for (int k = 0; k < 17; k++)
            send_beat(scm_pkg::CMD_LOAD_LEFT, 8'(k), 8'd1, 32'h00010000);
        send_beat(scm_pkg::CMD_LOAD_RIGHT, 8'd1, 8'd2, 32'h00000100);
        send_beat(scm_pkg::CMD_MULTIPLY, 8'd0, 8'd0, 32'd0);
        drain_results();

        // full result store: 16 x 16 all matching with distinct positions
        for (int k = 0; k < 16; k++)
            send_beat(scm_pkg::CMD_LOAD_LEFT, 8'(k), 8'd5, 32'h00020000);
        for (int k = 0; k < 16; k++)
            send_beat(scm_pkg::CMD_LOAD_RIGHT, 8'd5, 8'(k), 32'h00030000);
        send_beat(scm_pkg::CMD_MULTIPLY, 8'd0, 8'd0, 32'd0);
        drain_results();

        stall_enable = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_threshold(31'd0);
                1: write_threshold(31'h7fffffff);
                2: write_threshold(31'($urandom_range(0, 32'h20000)));
                default: write_threshold(31'd1311);
            endcase
            for (int m = 0; m < 2; m++)
                random_matrix_pair($urandom_range(0, 6), $urandom_range(0, 6));
            stall_enable = (phase != 2);
            drain_results();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/scm_pkg.sv
sv/scm_front.sv
sv/scm_queue.sv
sv/scm_engine.sv
sv/sparse_coo_matrix_multiply_top.sv
tb/scm_checker.sv
tb/testbench.sv
